@@ src/bsm_pkg.sv @@
// bouncing sprite motion: shared types, constants and fixed-point helpers
`default_nettype none

package bsm_pkg;

  localparam int SPD_W = 20;

  typedef logic signed [SPD_W-1:0] spd_t;
  typedef logic signed [SPD_W+1:0] spd_wide_t;

  localparam spd_t SPD_MAX = 20'sh7FFFF;
  localparam spd_t SPD_MIN = 20'sh80000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AREA_WIDTH    = 3'd0,
    REG_AREA_HEIGHT   = 3'd1,
    REG_GRAVITY_STEP  = 3'd2,
    REG_FRICTION_STEP = 3'd3,
    REG_BOUNCE_FACTOR = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_NUDGE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [11:0]       area_width;
    logic [11:0]       area_height;
    logic signed [6:0] gravity_step;
    logic [7:0]        friction_step;
    logic [8:0]        bounce_factor;
  } cfg_t;

  localparam logic [11:0]       RST_AREA_WIDTH    = 12'd1280;
  localparam logic [11:0]       RST_AREA_HEIGHT   = 12'd720;
  localparam logic signed [6:0] RST_GRAVITY_STEP  = 7'sd3;
  localparam logic [7:0]        RST_FRICTION_STEP = 8'd26;
  localparam logic [8:0]        RST_BOUNCE_FACTOR = 9'd205;

  localparam int   START_POS     = 50;
  localparam spd_t START_SPEED_X = 20'sd12800;
  localparam spd_t START_SPEED_Y = 20'sd0;

  function automatic spd_t sat_spd(spd_wide_t v);
    spd_t r;
    if (v > spd_wide_t'(SPD_MAX)) begin
      r = SPD_MAX;
    end else if (v < spd_wide_t'(SPD_MIN)) begin
      r = SPD_MIN;
    end else begin
      r = v[SPD_W-1:0];
    end
    return r;
  endfunction

  // pulls toward zero; may overshoot zero by less than one step, never leaves range
  function automatic spd_t friction(spd_t v, logic [7:0] f);
    spd_wide_t w;
    spd_wide_t fw;
    fw = spd_wide_t'({1'b0, f});
    if (v > 0) begin
      w = spd_wide_t'(v) - fw;
    end else if (v < 0) begin
      w = spd_wide_t'(v) + fw;
    end else begin
      w = '0;
    end
    return w[SPD_W-1:0];
  endfunction

  // negate, scale by Q1.8 factor on the magnitude, then saturate
  function automatic spd_t bounce(spd_t v, logic [8:0] bf);
    logic [SPD_W-1:0]   mag;
    logic [SPD_W+8:0]   prod;
    logic [SPD_W:0]     r;
    spd_wide_t          rs;
    mag  = v[SPD_W-1] ? SPD_W'(-v) : SPD_W'(v);
    prod = (SPD_W+9)'(mag) * (SPD_W+9)'(bf);
    r    = prod[SPD_W+8:8];
    rs   = spd_wide_t'({1'b0, r});
    return sat_spd(v[SPD_W-1] ? rs : -rs);
  endfunction

  function automatic spd_t add_nudge(spd_t v, logic signed [11:0] n);
    spd_wide_t nw;
    nw = spd_wide_t'($signed({n, 8'd0}));
    return sat_spd(spd_wide_t'(v) + nw);
  endfunction

endpackage

`default_nettype wire

@@ src/bouncing_sprite_motion_step_top.sv @@
// top level: request registers, configuration, sprite state and result channel
// a request is held in the input register, then moves into the state registers once the result slot is free
// throughput: one request per cycle while out_tready stays high; the state registers double as the result register
// an input register parts the two sides, so a request is taken while a result waits
// reset (rst_n low, synchronous): sprite at (50, 50), speed (50.0, 0), registers to defaults
// no clearing pass; the block accepts requests in the first cycle after reset
`default_nettype none

module bouncing_sprite_motion_step_top import bsm_pkg::*; #(
  parameter int SPRITE_SIZE = 50,
  parameter int POS_BITS    = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [23:0]           in_tdata,   // nudge_x[11:0], nudge_y[23:12]
  input  wire logic                  in_tuser,   // cmd[0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [71:0]                out_tdata,  // pos_x[11:0], pos_y[23:12],
                                                 // speed_x[43:24], speed_y[63:44],
                                                 // collided[64], zero fill above
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;

  logic               in_vld_r;
  logic               cmd_r;
  logic signed [11:0] nudge_x_r;
  logic signed [11:0] nudge_y_r;

  logic                out_vld_r;
  logic                coll_r;
  logic [POS_BITS-1:0] pos_x_r;
  logic [POS_BITS-1:0] pos_y_r;
  spd_t                spd_x_r;
  spd_t                spd_y_r;

  logic [POS_BITS-1:0] pos_x_nxt;
  logic [POS_BITS-1:0] pos_y_nxt;
  spd_t                spd_x_nxt;
  spd_t                spd_y_nxt;
  logic                hit_x;
  logic                hit_y;
  logic                advance;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.area_width    <= RST_AREA_WIDTH;
      cfg_r.area_height   <= RST_AREA_HEIGHT;
      cfg_r.gravity_step  <= RST_GRAVITY_STEP;
      cfg_r.friction_step <= RST_FRICTION_STEP;
      cfg_r.bounce_factor <= RST_BOUNCE_FACTOR;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_AREA_WIDTH:    cfg_r.area_width    <= cfg_wdata;
        REG_AREA_HEIGHT:   cfg_r.area_height   <= cfg_wdata;
        REG_GRAVITY_STEP:  cfg_r.gravity_step  <= $signed(cfg_wdata[6:0]);
        REG_FRICTION_STEP: cfg_r.friction_step <= cfg_wdata[7:0];
        REG_BOUNCE_FACTOR: cfg_r.bounce_factor <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r     <= in_tuser;
      nudge_x_r <= $signed(in_tdata[11:0]);
      nudge_y_r <= $signed(in_tdata[23:12]);
    end
  end

  bsm_x_step #(
    .POS_BITS    (POS_BITS),
    .SPRITE_SIZE (SPRITE_SIZE)
  ) u_x_step (
    .cmd     (cmd_r),
    .nudge   (nudge_x_r),
    .cfg     (cfg_r),
    .pos     (pos_x_r),
    .spd     (spd_x_r),
    .pos_nxt (pos_x_nxt),
    .spd_nxt (spd_x_nxt),
    .hit     (hit_x)
  );

  bsm_y_step #(
    .POS_BITS    (POS_BITS),
    .SPRITE_SIZE (SPRITE_SIZE)
  ) u_y_step (
    .cmd     (cmd_r),
    .nudge   (nudge_y_r),
    .cfg     (cfg_r),
    .pos     (pos_y_r),
    .spd     (spd_y_r),
    .pos_nxt (pos_y_nxt),
    .spd_nxt (spd_y_nxt),
    .hit     (hit_y)
  );

  // state only moves when the result slot is free, so it always mirrors the shown result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      coll_r    <= 1'b0;
      pos_x_r   <= POS_BITS'(START_POS);
      pos_y_r   <= POS_BITS'(START_POS);
      spd_x_r   <= START_SPEED_X;
      spd_y_r   <= START_SPEED_Y;
    end else begin
      if (advance) begin
        out_vld_r <= 1'b1;
        coll_r    <= hit_x || hit_y;
        pos_x_r   <= pos_x_nxt;
        pos_y_r   <= pos_y_nxt;
        spd_x_r   <= spd_x_nxt;
        spd_y_r   <= spd_y_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, coll_r, spd_y_r, spd_x_r, 12'(pos_y_r), 12'(pos_x_r)};

  a_nudge_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cmd_r == CMD_NUDGE) |=> !coll_r)
    else $error("nudge request flagged a collision");

  a_nudge_holds_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cmd_r == CMD_NUDGE) |=>
      (pos_x_r == $past(pos_x_r) && pos_y_r == $past(pos_y_r)))
    else $error("nudge request moved the sprite");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_tready)
    else $error("input stalled with the result slot empty");

  a_valid_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(advance))
    else $error("result appeared without a request behind it");

endmodule

`default_nettype wire

@@ src/bsm_x_step.sv @@
// horizontal axis update: nudge, friction, snap, move and wall bounce
`default_nettype none

module bsm_x_step import bsm_pkg::*; #(
  parameter int POS_BITS    = 12,
  parameter int SPRITE_SIZE = 50
) (
  input  wire logic                cmd,
  input  wire logic signed [11:0]  nudge,
  input  wire cfg_t                cfg,
  input  wire logic [POS_BITS-1:0] pos,
  input  wire spd_t                spd,
  output logic [POS_BITS-1:0]      pos_nxt,
  output spd_t                     spd_nxt,
  output logic                     hit
);

  localparam int SW  = ((POS_BITS + 9 > SPD_W + 1) ? POS_BITS + 9 : SPD_W + 1) + 1;
  localparam int NPW = SW - 8;

  spd_t                  spd_f;
  logic signed [SW-1:0]  sum_s;
  logic signed [SW-1:0]  sum_adj;
  logic signed [NPW-1:0] np;
  logic signed [NPW-1:0] np_cl;
  logic signed [13:0]    lim_diff;
  logic signed [NPW-1:0] lim;

  always_comb begin
    lim_diff = $signed({2'b00, cfg.area_width}) - 14'(SPRITE_SIZE);
    lim      = (lim_diff < 0) ? '0 : NPW'(lim_diff);

    spd_f = friction(spd, cfg.friction_step);
    // small speeds stop dead
    if (spd_f >= -spd_t'(256) && spd_f <= spd_t'(256)) begin
      spd_f = '0;
    end

    sum_s   = $signed({{(SW-POS_BITS-8){1'b0}}, pos, 8'd0}) + SW'(spd_f);
    // truncate toward zero
    sum_adj = sum_s + ((sum_s < 0) ? SW'(255) : SW'(0));
    np      = sum_adj[SW-1:8];

    pos_nxt = pos;
    spd_nxt = spd;
    hit     = 1'b0;
    np_cl   = np;
    case (cmd)
      CMD_NUDGE: begin
        spd_nxt = add_nudge(spd, nudge);
      end
      default: begin
        spd_nxt = spd_f;
        if (np < 0) begin
          np_cl   = '0;
          spd_nxt = bounce(spd_f, cfg.bounce_factor);
          hit     = 1'b1;
        end else if (np >= lim) begin
          np_cl   = lim;
          spd_nxt = bounce(spd_f, cfg.bounce_factor);
          hit     = 1'b1;
        end
        pos_nxt = np_cl[POS_BITS-1:0];
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/bsm_y_step.sv @@
// vertical axis update: nudge, gravity, friction, move, bounce and floor stop
`default_nettype none

module bsm_y_step import bsm_pkg::*; #(
  parameter int POS_BITS    = 12,
  parameter int SPRITE_SIZE = 50
) (
  input  wire logic                cmd,
  input  wire logic signed [11:0]  nudge,
  input  wire cfg_t                cfg,
  input  wire logic [POS_BITS-1:0] pos,
  input  wire spd_t                spd,
  output logic [POS_BITS-1:0]      pos_nxt,
  output spd_t                     spd_nxt,
  output logic                     hit
);

  localparam int SW  = ((POS_BITS + 9 > SPD_W + 1) ? POS_BITS + 9 : SPD_W + 1) + 1;
  localparam int NPW = SW - 8;

  spd_wide_t             g_w;
  spd_t                  spd_g;
  spd_t                  spd_f;
  spd_t                  spd_b;
  spd_wide_t             mag_b;
  logic signed [SW-1:0]  sum_s;
  logic signed [SW-1:0]  sum_adj;
  logic signed [NPW-1:0] np;
  logic signed [NPW-1:0] np_cl;
  logic signed [13:0]    lim_diff;
  logic signed [NPW-1:0] lim;

  always_comb begin
    lim_diff = $signed({2'b00, cfg.area_height}) - 14'(SPRITE_SIZE);
    lim      = (lim_diff < 0) ? '0 : NPW'(lim_diff);

    g_w   = spd_wide_t'($signed({cfg.gravity_step, 8'd0}));
    spd_g = sat_spd(spd_wide_t'(spd) + g_w);
    spd_f = friction(spd_g, cfg.friction_step);

    sum_s   = $signed({{(SW-POS_BITS-8){1'b0}}, pos, 8'd0}) + SW'(spd_f);
    sum_adj = sum_s + ((sum_s < 0) ? SW'(255) : SW'(0));
    np      = sum_adj[SW-1:8];

    spd_b = bounce(spd_f, cfg.bounce_factor);
    mag_b = spd_b[SPD_W-1] ? -spd_wide_t'(spd_b) : spd_wide_t'(spd_b);

    pos_nxt = pos;
    spd_nxt = spd;
    hit     = 1'b0;
    np_cl   = np;
    case (cmd)
      CMD_NUDGE: begin
        spd_nxt = add_nudge(spd, nudge);
      end
      default: begin
        spd_nxt = spd_f;
        if (np < 0) begin
          np_cl   = '0;
          spd_nxt = spd_b;
          hit     = 1'b1;
        end else if (np > lim) begin
          // resting on the floor: a rebound weaker than gravity stops
          np_cl   = lim;
          spd_nxt = (mag_b < g_w) ? '0 : spd_b;
          hit     = 1'b1;
        end
        pos_nxt = np_cl[POS_BITS-1:0];
      end
    endcase
  end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// testbench for the bouncing sprite motion step, checked against a local predictor
module tb;
  import bsm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     SPRITE     = 50;
  localparam longint Q8_ONE     = 256;
  localparam longint SPEED_HI   = 524287;
  localparam longint SPEED_LO   = -524288;
  localparam int     CYCLE_CAP  = 500000;
  localparam int     PRINT_CAP  = 40;

  // result word as it leaves the block, lowest field last
  typedef struct packed {
    logic [6:0]         fill;
    logic               collided;
    logic signed [19:0] speed_y;
    logic signed [19:0] speed_x;
    logic [11:0]        pos_y;
    logic [11:0]        pos_x;
  } motion_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata   = '0;    // nudge_x[11:0], nudge_y[23:12]
  logic                  in_tuser   = 1'b0;  // cmd[0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [71:0]           out_tdata;          // pos_x[11:0], pos_y[23:12], speed_x[43:24],
                                             // speed_y[63:44], collided[64], zero fill
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // register mirror
  int     area_w;
  int     area_h;
  int     grav;
  int     drag_step;
  int     bounce_q8;

  // sprite state mirror
  longint sprite_x;
  longint sprite_y;
  longint speed_x_q8;
  longint speed_y_q8;

  motion_t pending_motion[$];

  bit  idle_on   = 1'b0;
  int  hold_left = 0;
  int  mismatches = 0;
  int  requests_sent = 0;
  int  results_seen = 0;
  int  settings = 0;
  int  cycles = 0;

  bouncing_sprite_motion_step_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_motion.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_speed(longint v);
    if (v > SPEED_HI) return SPEED_HI;
    if (v < SPEED_LO) return SPEED_LO;
    return v;
  endfunction

  function automatic longint apply_drag(longint v);
    if (v > 0) return v - drag_step;
    if (v < 0) return v + drag_step;
    return 0;
  endfunction

  // truncates toward zero
  function automatic longint move_axis(longint p, longint v);
    longint s;
    s = p * Q8_ONE + v;
    return (s >= 0) ? s / Q8_ONE : -((-s) / Q8_ONE);
  endfunction

  function automatic longint rebound_speed(longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag * bounce_q8) / Q8_ONE;
    return clamp_speed((v < 0) ? mag : -mag);
  endfunction

  function automatic motion_t advance_sprite(cmd_t op, logic signed [11:0] nx,
                                              logic signed [11:0] ny);
    motion_t r;
    longint  lim_x;
    longint  lim_y;
    longint  g;
    longint  np;
    logic    hit;
    r   = '0;
    hit = 1'b0;
    if (op == CMD_NUDGE) begin
      speed_x_q8 = clamp_speed(speed_x_q8 + longint'(nx) * Q8_ONE);
      speed_y_q8 = clamp_speed(speed_y_q8 + longint'(ny) * Q8_ONE);
    end else begin
      lim_x = (area_w > SPRITE) ? area_w - SPRITE : 0;
      lim_y = (area_h > SPRITE) ? area_h - SPRITE : 0;
      g     = longint'(grav) * Q8_ONE;

      speed_x_q8 = apply_drag(speed_x_q8);
      if (speed_x_q8 <= Q8_ONE && speed_x_q8 >= -Q8_ONE) speed_x_q8 = 0;
      np = move_axis(sprite_x, speed_x_q8);
      if (np < 0) begin
        np = 0;
        speed_x_q8 = rebound_speed(speed_x_q8);
        hit = 1'b1;
      end else if (np >= lim_x) begin
        np = lim_x;
        speed_x_q8 = rebound_speed(speed_x_q8);
        hit = 1'b1;
      end
      sprite_x = np & 4095;

      speed_y_q8 = clamp_speed(speed_y_q8 + g);
      speed_y_q8 = apply_drag(speed_y_q8);
      np = move_axis(sprite_y, speed_y_q8);
      if (np < 0) begin
        np = 0;
        speed_y_q8 = rebound_speed(speed_y_q8);
        hit = 1'b1;
      end else if (np > lim_y) begin
        np = lim_y;
        speed_y_q8 = rebound_speed(speed_y_q8);
        // weak rebound off the floor dies out
        if (((speed_y_q8 < 0) ? -speed_y_q8 : speed_y_q8) < g) speed_y_q8 = 0;
        hit = 1'b1;
      end
      sprite_y = np & 4095;
    end
    r.pos_x    = sprite_x[11:0];
    r.pos_y    = sprite_y[11:0];
    r.speed_x  = speed_x_q8[19:0];
    r.speed_y  = speed_y_q8[19:0];
    r.collided = hit;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(cmd_t op, logic [11:0] nx, logic [11:0] ny);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {ny, nx};
    do @(posedge clk); while (!in_tready);
    pending_motion.push_back(advance_sprite(op, nx, ny));
    requests_sent++;
  endtask

  // always steps the clock before it tests the queue, so a following request never lands in the same step
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_motion.size() != 0);
  endtask

  task automatic set_config(logic [11:0] aw, logic [11:0] ah, logic signed [6:0] g,
                            logic [7:0] f, logic [8:0] b);
    cfg_we    <= 1'b1;
    cfg_index <= REG_AREA_WIDTH;
    cfg_wdata <= aw;
    @(posedge clk);
    cfg_index <= REG_AREA_HEIGHT;
    cfg_wdata <= ah;
    @(posedge clk);
    cfg_index <= REG_GRAVITY_STEP;
    cfg_wdata <= CFG_DATA_W'(g);
    @(posedge clk);
    cfg_index <= REG_FRICTION_STEP;
    cfg_wdata <= CFG_DATA_W'(f);
    @(posedge clk);
    cfg_index <= REG_BOUNCE_FACTOR;
    cfg_wdata <= CFG_DATA_W'(b);
    @(posedge clk);
    cfg_we    <= 1'b0;
    area_w    = int'(aw);
    area_h    = int'(ah);
    grav      = int'(g);
    drag_step = int'(f);
    bounce_q8 = int'(b);
    settings++;
  endtask

  // result side: random stalls, plus a long hold-off when asked
  initial begin
    int rx_wait;
    rx_wait = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on) rx_wait = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    motion_t got;
    motion_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = motion_t'(out_tdata);
      if (pending_motion.size() == 0) begin
        report_mismatch("unexpected result, pos_x", got.pos_x, -1);
      end else begin
        want = pending_motion.pop_front();
        if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
        if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
        if (got.speed_x !== want.speed_x)
          report_mismatch("speed_x", got.speed_x, want.speed_x);
        if (got.speed_y !== want.speed_y)
          report_mismatch("speed_y", got.speed_y, want.speed_y);
        if (got.collided !== want.collided)
          report_mismatch("collided", got.collided, want.collided);
        if (got.fill !== '0) report_mismatch("zero fill", got.fill, 0);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    // reset settings: saturate both speeds, hit right wall and floor, then left wall and ceiling
    send_item(CMD_TICK, 12'h000, 12'h000);
    send_item(CMD_NUDGE, 12'h7FF, 12'h7FF);
    send_item(CMD_TICK, 12'hFFF, 12'hFFF);
    send_item(CMD_NUDGE, 12'h800, 12'h800);
    send_item(CMD_NUDGE, 12'h800, 12'h800);
    send_item(CMD_TICK, 12'h555, 12'hAAA);
    send_item(CMD_NUDGE, 12'h000, 12'h000);
    send_item(CMD_TICK, 12'h000, 12'h000);
    wait_drain();

    // area narrower than the sprite, dead bounce: land on the floor and stop
    set_config(12'd0, 12'd64, 3, 8'd0, 9'd0);
    send_item(CMD_NUDGE, 12'h001, 12'h7FF);
    send_item(CMD_TICK, 12'h000, 12'h000);
    send_item(CMD_NUDGE, 12'h001, 12'h000);
    wait_drain();

    // resting exactly on the floor is no hit; x speed of one unit snaps to zero
    set_config(12'd1280, 12'd64, 0, 8'd0, 9'd256);
    send_item(CMD_TICK, 12'h000, 12'h000);
    wait_drain();

    // negative gravity, full friction, restitution beyond unity
    set_config(12'd4095, 12'd4095, -64, 8'd255, 9'd511);
    send_item(CMD_TICK, 12'h000, 12'h000);
    send_item(CMD_NUDGE, 12'h7FF, 12'h7FF);
    send_item(CMD_TICK, 12'h000, 12'h000);
    send_item(CMD_NUDGE, 12'h000, 12'h7FF);
    send_item(CMD_TICK, 12'h000, 12'h000);
    send_item(CMD_TICK, 12'h000, 12'h000);
    send_item(CMD_NUDGE, 12'hFFF, 12'hFFF);
    send_item(CMD_TICK, 12'h000, 12'h000);
    wait_drain();
  endtask

  task automatic test_random_phases();
    int ph;
    int i;
    int r;
    int aw;
    int ah;
    int gv;
    int bf;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(12'd64, 12'd64, -64, 8'd0, 9'd0);
        1: set_config(12'd4095, 12'd4095, 63, 8'd255, 9'd256);
        2: set_config(12'd1280, 12'd720, 3, 8'd26, 9'd205);
        default: begin
          aw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(64, 4095);
          ah = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(64, 700);
          gv = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(0, 127) - 64;
          bf = ($urandom_range(0, 9) < 8) ? $urandom_range(128, 256) : $urandom_range(0, 511);
          set_config(12'(aw), 12'(ah), 7'(gv), 8'($urandom), 9'(bf));
        end
      endcase
      idle_on = (ph % 3 != 2);
      for (i = 0; i < 130; i++) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          send_item(CMD_TICK, 12'($urandom), 12'($urandom));
        end else if (r < 92) begin
          send_item(CMD_NUDGE, 12'($urandom_range(0, 32) - 16), 12'($urandom_range(0, 32) - 16));
        end else begin
          send_item(CMD_NUDGE, 12'($urandom), 12'($urandom));
        end
        // sender rests until the block has emptied
        if (i == 65 && ph % 2 == 0) wait_drain();
      end
      wait_drain();
    end
  endtask

  task automatic test_backpressure();
    int i;
    idle_on   = 1'b0;
    hold_left = 80;
    for (i = 0; i < 30; i++) begin
      if (i % 4 == 0) begin
        send_item(CMD_NUDGE, 12'($urandom_range(0, 20) - 10), 12'($urandom_range(0, 20) - 10));
      end else begin
        send_item(CMD_TICK, 12'($urandom), 12'($urandom));
      end
    end
    wait_drain();
  endtask

  initial begin
    area_w     = int'(RST_AREA_WIDTH);
    area_h     = int'(RST_AREA_HEIGHT);
    grav       = int'(RST_GRAVITY_STEP);
    drag_step  = int'(RST_FRICTION_STEP);
    bounce_q8  = int'(RST_BOUNCE_FACTOR);
    sprite_x   = START_POS;
    sprite_y   = START_POS;
    speed_x_q8 = longint'(START_SPEED_X);
    speed_y_q8 = longint'(START_SPEED_Y);

    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_phases();
    test_backpressure();

    repeat (8) @(posedge clk);
    $display("summary: %0d requests, %0d results checked over %0d register settings",
             requests_sent, results_seen, settings);
    $display("summary: %0d mismatches, with stalls, a long output hold-off and drained pauses",
             mismatches);
    if (mismatches == 0 && pending_motion.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
